[sv/iovart_pkg.sv]
// Package for the address region translation table.
// Holds the table size, index and count widths, opcode and status codes, and the entry types.
// Has no dependencies; the match module and the top level use it.
package iovart_pkg;

  localparam int unsigned TABLE_ENTRIES = 8;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  // The last address and the sum of base and offset are kept instead of the size,
  // since every test and the translation only ever need those values.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] last;
    logic [ADDR_W-1:0] bsum;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic covered;
  } match_t;

  function automatic logic [3:0] cnt_to_nib(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+3:0] ext;
    ext = {4'b0000, cnt};
    return ext[3:0];
  endfunction

endpackage

[sv/iovart_match.sv]
// Region tests for one table entry against the current request.
// Computes the lookup hit, the removal coverage and the offset into the region.
// Depends on iovart_pkg.
module iovart_match (
  input  iovart_pkg::entry_t                 entry_i,
  input  logic [iovart_pkg::ADDR_W-1:0]      addr_start_i,
  input  logic [iovart_pkg::ADDR_W-1:0]      addr_last_i,
  output iovart_pkg::match_t                 match_o,
  output logic [iovart_pkg::ADDR_W-1:0]      diff_o
);

  logic [iovart_pkg::ADDR_W-1:0] end_excl;

  assign end_excl = entry_i.last + iovart_pkg::ADDR_W'(1);

  assign match_o.hit     = (addr_start_i >= entry_i.start) && (addr_start_i < end_excl);
  assign match_o.covered = (addr_start_i <= entry_i.start) && (addr_last_i >= entry_i.last);
  assign diff_o          = addr_start_i - entry_i.start;

endmodule

[sv/iova_region_translation_table_unit.sv]
// Address region translation table: lookup, add and remove over a table held in one RAM.
// From accepted start to done_o: a lookup reads entries in order up to the first hit and
// then sums the address in S_SUM; a lookup miss and a remove read every entry, one RAM
// read per entry; an add stops at the first free slot. busy is low in the cycle of done_o.
// The receiver cannot stall; each result is valid only while done_o is high.
// Reset clears all valid bits and the region count; RAM contents are left undefined.
module iova_region_translation_table_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        opcode_i,
  input  logic [iovart_pkg::ADDR_W-1:0]     addr_start_i,
  input  logic [iovart_pkg::ADDR_W-1:0]     addr_last_i,
  input  logic [iovart_pkg::ADDR_W-1:0]     target_base_i,
  input  logic [iovart_pkg::ADDR_W-1:0]     target_offset_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic [iovart_pkg::ADDR_W-1:0]     translated_addr_o,
  output logic [3:0]                        regions_in_use_o,
  output logic [3:0]                        removed_count_o
);

  localparam int unsigned N  = iovart_pkg::TABLE_ENTRIES;
  localparam int unsigned IW = iovart_pkg::IDX_W;
  localparam int unsigned CW = iovart_pkg::CNT_W;
  localparam int unsigned AW = iovart_pkg::ADDR_W;
  localparam logic [IW-1:0] LastIdx = IW'(N - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ADD  = 2'd2;
  localparam logic [1:0] S_SUM  = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [IW-1:0]           cnt_q, cnt_d;
  logic                    issue_q, issue_d;
  logic                    pend_q, pend_d;
  logic [IW-1:0]           pend_idx_q, pend_idx_d;
  logic [N-1:0]            valid_q, valid_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           removed_q, removed_d;
  logic                    done_q, done_d;
  logic                    lookup_q, lookup_d;
  iovart_pkg::status_e     status_q, status_d;
  logic [AW-1:0]           xlat_q, xlat_d;
  logic [AW-1:0]           diff_q, diff_d;
  logic [AW-1:0]           bsum_q, bsum_d;
  logic [AW-1:0]           req_a0_q, req_a0_d;
  logic [AW-1:0]           req_a1_q, req_a1_d;
  logic [AW-1:0]           req_base_q, req_base_d;
  logic [AW-1:0]           req_ofs_q, req_ofs_d;

  iovart_pkg::entry_t      mem_q [N];
  iovart_pkg::entry_t      rdata_q;
  iovart_pkg::entry_t      mem_wdata;
  logic                    mem_we;

  iovart_pkg::match_t      match;
  logic [AW-1:0]           match_diff;
  logic                    accept;

  iovart_match u_match (
    .entry_i      (rdata_q),
    .addr_start_i (req_a0_q),
    .addr_last_i  (req_a1_q),
    .match_o      (match),
    .diff_o       (match_diff)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    issue_d    = issue_q;
    valid_d    = valid_q;
    count_d    = count_q;
    removed_d  = removed_q;
    done_d     = 1'b0;
    lookup_d   = lookup_q;
    status_d   = status_q;
    xlat_d     = xlat_q;
    diff_d     = diff_q;
    bsum_d     = bsum_q;
    req_a0_d   = req_a0_q;
    req_a1_d   = req_a1_q;
    req_base_d = req_base_q;
    req_ofs_d  = req_ofs_q;
    mem_we     = 1'b0;
    mem_wdata  = '{start: req_a0_q, last: req_a1_q, bsum: req_base_q + req_ofs_q};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_a0_d   = addr_start_i;
          req_a1_d   = addr_last_i;
          req_base_d = target_base_i;
          req_ofs_d  = target_offset_i;
          removed_d  = '0;
          xlat_d     = '0;
          cnt_d      = '0;
          lookup_d   = 1'b0;
          unique case (iovart_pkg::opcode_e'(opcode_i))
            iovart_pkg::OP_LOOKUP: begin
              lookup_d = 1'b1;
              issue_d  = 1'b1;
              state_d  = S_SCAN;
            end
            iovart_pkg::OP_ADD: begin
              if (target_base_i != '0) begin
                state_d = S_ADD;
              end else begin
                status_d = iovart_pkg::ST_IGNORED;
                done_d   = 1'b1;
              end
            end
            iovart_pkg::OP_REMOVE: begin
              if (addr_start_i != addr_last_i) begin
                issue_d = 1'b1;
                state_d = S_SCAN;
              end else begin
                status_d = iovart_pkg::ST_IGNORED;
                done_d   = 1'b1;
              end
            end
            default: begin
              status_d = iovart_pkg::ST_IGNORED;
              done_d   = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (issue_q) begin
          if (cnt_q == LastIdx) begin
            issue_d = 1'b0;
          end else begin
            cnt_d = cnt_q + IW'(1);
          end
        end
        if (pend_q) begin
          if (lookup_q) begin
            if (valid_q[pend_idx_q] && match.hit) begin
              diff_d  = match_diff;
              bsum_d  = rdata_q.bsum;
              issue_d = 1'b0;
              state_d = S_SUM;
            end else if (pend_idx_q == LastIdx) begin
              status_d = iovart_pkg::ST_MISS;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end
          end else begin
            if (valid_q[pend_idx_q] && match.covered) begin
              valid_d[pend_idx_q] = 1'b0;
              count_d             = count_q - CW'(1);
              removed_d           = removed_q + CW'(1);
            end
            if (pend_idx_q == LastIdx) begin
              status_d = iovart_pkg::ST_OK;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end
          end
        end
      end
      S_ADD: begin
        if (!valid_q[cnt_q]) begin
          mem_we         = 1'b1;
          valid_d[cnt_q] = 1'b1;
          count_d        = count_q + CW'(1);
          status_d       = iovart_pkg::ST_OK;
          done_d         = 1'b1;
          state_d        = S_IDLE;
        end else if (cnt_q == LastIdx) begin
          status_d = iovart_pkg::ST_FULL;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end
      S_SUM: begin
        xlat_d   = diff_q + bsum_q;
        status_d = iovart_pkg::ST_OK;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    pend_d     = issue_q && (state_d == S_SCAN);
    pend_idx_d = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      issue_q    <= 1'b0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      valid_q    <= '0;
      count_q    <= '0;
      done_q     <= 1'b0;
      lookup_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      issue_q    <= issue_d;
      pend_q     <= pend_d;
      pend_idx_q <= pend_idx_d;
      valid_q    <= valid_d;
      count_q    <= count_d;
      done_q     <= done_d;
      lookup_q   <= lookup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    removed_q  <= removed_d;
    status_q   <= status_d;
    xlat_q     <= xlat_d;
    diff_q     <= diff_d;
    bsum_q     <= bsum_d;
    req_a0_q   <= req_a0_d;
    req_a1_q   <= req_a1_d;
    req_base_q <= req_base_d;
    req_ofs_q  <= req_ofs_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cnt_q] <= mem_wdata;
    end
    rdata_q <= mem_q[cnt_q];
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign translated_addr_o = xlat_q;
  assign regions_in_use_o  = iovart_pkg::cnt_to_nib(count_q);
  assign removed_count_o   = iovart_pkg::cnt_to_nib(removed_q);

`ifndef SYNTHESIS
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("Accepted request neither started work nor produced a result.");

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("Region count differs from the number of valid entries.");

  a_xlat_zero_unless_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != iovart_pkg::ST_OK)) |-> (translated_addr_o == '0))
    else $error("Translated address is nonzero on a result that is not a hit.");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == iovart_pkg::ST_FULL)) |-> (valid_q == {N{1'b1}}))
    else $error("Table full reported while a slot is free.");
`endif

endmodule

[verif/tb.sv]
// Self-checking testbench for iova_region_translation_table_unit.
// Drives lookup, add and remove transfers from a queue and predicts every reply from a
// private copy of the region table. Depends only on iovart_pkg and the unit itself.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [63:0] ALL_ONES = '1;
  localparam int unsigned RANDOM_REQUESTS = 1926;
  localparam int unsigned STALL_LIMIT = 1000;

  typedef struct {
    logic [1:0]  opcode;
    logic [63:0] addr_start;
    logic [63:0] addr_last;
    logic [63:0] base;
    logic [63:0] ofs;
  } request_t;

  typedef struct {
    iovart_pkg::status_e status;
    logic [63:0]         xlat;
    logic [3:0]          in_use;
    logic [3:0]          removed;
  } reply_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
  } span_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode_i = iovart_pkg::OP_LOOKUP;
  logic [63:0] addr_start_i = '0;
  logic [63:0] addr_last_i = '0;
  logic [63:0] target_base_i = '0;
  logic [63:0] target_offset_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [63:0] translated_addr_o;
  logic [3:0]  regions_in_use_o;
  logic [3:0]  removed_count_o;

  request_t    request_fifo[$];
  reply_t      outstanding_replies[$];
  span_t       recent_spans[$];
  int unsigned total_requests;
  int unsigned issued = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  logic        took = 1'b0;

  logic        tbl_valid[iovart_pkg::TABLE_ENTRIES];
  logic [63:0] tbl_start[iovart_pkg::TABLE_ENTRIES];
  logic [63:0] tbl_size[iovart_pkg::TABLE_ENTRIES];
  logic [63:0] tbl_base[iovart_pkg::TABLE_ENTRIES];
  logic [63:0] tbl_ofs[iovart_pkg::TABLE_ENTRIES];
  int unsigned tbl_count = 0;

  iova_region_translation_table_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode_i),
    .addr_start_i      (addr_start_i),
    .addr_last_i       (addr_last_i),
    .target_base_i     (target_base_i),
    .target_offset_i   (target_offset_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .translated_addr_o (translated_addr_o),
    .regions_in_use_o  (regions_in_use_o),
    .removed_count_o   (removed_count_o)
  );

  function automatic reply_t table_access(input request_t rq);
    reply_t      rp;
    logic        found;
    int unsigned dropped;
    rp.status = iovart_pkg::ST_IGNORED;
    rp.xlat = '0;
    found = 1'b0;
    dropped = 0;
    case (rq.opcode)
      iovart_pkg::OP_LOOKUP: begin
        rp.status = iovart_pkg::ST_MISS;
        for (int k = 0; k < iovart_pkg::TABLE_ENTRIES; k++) begin
          if (!found && tbl_valid[k] && rq.addr_start >= tbl_start[k] &&
              rq.addr_start < tbl_start[k] + tbl_size[k]) begin
            rp.xlat = rq.addr_start - tbl_start[k] + tbl_base[k] + tbl_ofs[k];
            rp.status = iovart_pkg::ST_OK;
            found = 1'b1;
          end
        end
      end
      iovart_pkg::OP_ADD: begin
        if (rq.base != '0) begin
          rp.status = iovart_pkg::ST_FULL;
          for (int k = 0; k < iovart_pkg::TABLE_ENTRIES; k++) begin
            if (!found && !tbl_valid[k]) begin
              tbl_valid[k] = 1'b1;
              tbl_start[k] = rq.addr_start;
              tbl_size[k] = rq.addr_last - rq.addr_start + 64'd1;
              tbl_base[k] = rq.base;
              tbl_ofs[k] = rq.ofs;
              tbl_count++;
              rp.status = iovart_pkg::ST_OK;
              found = 1'b1;
            end
          end
        end
      end
      iovart_pkg::OP_REMOVE: begin
        if (rq.addr_start != rq.addr_last) begin
          rp.status = iovart_pkg::ST_OK;
          for (int k = 0; k < iovart_pkg::TABLE_ENTRIES; k++) begin
            if (tbl_valid[k] && rq.addr_start <= tbl_start[k] &&
                rq.addr_last >= tbl_start[k] + tbl_size[k] - 64'd1) begin
              tbl_valid[k] = 1'b0;
              tbl_count--;
              dropped++;
            end
          end
        end
      end
      default: rp.status = iovart_pkg::ST_IGNORED;
    endcase
    rp.in_use = tbl_count[3:0];
    rp.removed = dropped[3:0];
    return rp;
  endfunction

  function automatic void push_request(input logic [1:0] op, input logic [63:0] a0,
                                       input logic [63:0] a1, input logic [63:0] b,
                                       input logic [63:0] o);
    request_t rq;
    rq.opcode = op;
    rq.addr_start = a0;
    rq.addr_last = a1;
    rq.base = b;
    rq.ofs = o;
    request_fifo.push_back(rq);
  endfunction

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!start || took)) begin
      if (request_fifo.size() != 0 &&
          $urandom_range(99) >= ((issued < total_requests / 3) ? 12 :
                                 (issued < 2 * total_requests / 3) ? 71 : 0)) begin
        opcode_i <= request_fifo[0].opcode;
        addr_start_i <= request_fifo[0].addr_start;
        addr_last_i <= request_fifo[0].addr_last;
        target_base_i <= request_fifo[0].base;
        target_offset_i <= request_fifo[0].ofs;
        start <= 1'b1;
        void'(request_fifo.pop_front());
        issued++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      took <= start && !busy;
      if (done_o) begin
        if (outstanding_replies.size() == 0) begin
          $display("%0t: unexpected reply, expected none, got status %0d addr %h", $time,
                   status_o, translated_addr_o);
          mismatches++;
        end else begin
          check_field("status", outstanding_replies[0].status, status_o);
          check_field("translated_addr", outstanding_replies[0].xlat, translated_addr_o);
          check_field("regions_in_use", outstanding_replies[0].in_use, regions_in_use_o);
          check_field("removed_count", outstanding_replies[0].removed, removed_count_o);
          void'(outstanding_replies.pop_front());
        end
      end
      if (start && !busy) begin
        outstanding_replies.push_back(table_access('{opcode_i, addr_start_i, addr_last_i,
                                                     target_base_i, target_offset_i}));
      end
      stall_cycles <= (done_o || (start && !busy)) ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("FAIL iova_region_translation_table_unit");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] a0, a1, b, o, lo, hi, span;
    int unsigned pick, k;
    span_t       sp;

    for (int i = 0; i < iovart_pkg::TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
    end

    push_request(iovart_pkg::OP_LOOKUP, 64'h0, 64'h0, 64'h0, 64'h0);
    push_request(iovart_pkg::OP_REMOVE, 64'h0, ALL_ONES, 64'h0, 64'h0);
    push_request(iovart_pkg::OP_REMOVE, 64'h5000, 64'h5000, 64'h1, 64'h0);
    push_request(OP_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    push_request(iovart_pkg::OP_ADD, 64'h1000, 64'h1fff, 64'h0, 64'h77);
    push_request(iovart_pkg::OP_ADD, 64'h1000, 64'h1fff, ALL_ONES, ALL_ONES);
    push_request(iovart_pkg::OP_LOOKUP, 64'h1000, 64'h0, 64'h0, 64'h0);
    push_request(iovart_pkg::OP_LOOKUP, 64'h1fff, 64'h0, 64'h0, 64'h0);
    push_request(iovart_pkg::OP_LOOKUP, 64'h2000, 64'h0, 64'h0, 64'h0);
    push_request(iovart_pkg::OP_LOOKUP, 64'h0fff, 64'h0, 64'h0, 64'h0);
    push_request(iovart_pkg::OP_ADD, 64'hffff_ffff_ffff_f000, 64'h0fff, 64'h1, 64'h0);
    push_request(iovart_pkg::OP_LOOKUP, ALL_ONES, 64'h0, 64'h0, 64'h0);
    push_request(iovart_pkg::OP_LOOKUP, 64'h0800, 64'h0, 64'h0, 64'h0);
    push_request(iovart_pkg::OP_ADD, 64'h0, ALL_ONES, 64'h8000_0000_0000_0000, 64'h0);
    push_request(iovart_pkg::OP_ADD, 64'h1800, 64'h18ff, 64'h10_0000, 64'h20);
    push_request(iovart_pkg::OP_LOOKUP, 64'h1800, 64'h0, 64'h0, 64'h0);
    for (int i = 1; i <= 4; i++) begin
      push_request(iovart_pkg::OP_ADD, 64'h10_0000 * i, 64'h10_0000 * i + 64'hff, 64'h1,
                   64'h0);
    end
    push_request(iovart_pkg::OP_ADD, 64'h9000, 64'h9fff, 64'h1, 64'h0);
    push_request(iovart_pkg::OP_REMOVE, 64'h1000, 64'h1fff, 64'h0, 64'h0);
    push_request(iovart_pkg::OP_REMOVE, 64'h0, ALL_ONES, 64'h0, 64'h0);
    push_request(iovart_pkg::OP_LOOKUP, 64'h1000, 64'h0, 64'h0, 64'h0);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(99);
      a0 = {$urandom, $urandom};
      a1 = {$urandom, $urandom};
      b = {$urandom, $urandom};
      o = {$urandom, $urandom};
      lo = '0;
      hi = '0;
      if (recent_spans.size() != 0) begin
        k = $urandom_range(recent_spans.size() - 1);
        lo = recent_spans[k].lo;
        hi = recent_spans[k].hi;
      end
      if (pick < 45) begin
        if (recent_spans.size() != 0 && $urandom_range(9) < 8) begin
          case ($urandom_range(5))
            0: a0 = lo;
            1: a0 = hi;
            2: a0 = hi + 64'd1;
            3: a0 = lo - 64'd1;
            default: begin
              span = hi - lo;
              if (span != ALL_ONES) begin
                a0 = lo + a0 % (span + 64'd1);
              end
            end
          endcase
        end
        push_request(iovart_pkg::OP_LOOKUP, a0, a1, b, o);
      end else if (pick < 75) begin
        case ($urandom_range(9))
          0: ;
          1: a1 = a0 - 64'd1;
          2: a1 = a0 + $urandom_range(0, 65535);
          default: begin
            a0 = 64'h4000_0000 + ($urandom_range(0, 63) << 8);
            a1 = a0 + $urandom_range(0, 1023);
          end
        endcase
        if ($urandom_range(19) == 0) begin
          b = '0;
        end else if (b == '0) begin
          b = 64'h1;
        end
        sp.lo = a0;
        sp.hi = a1;
        recent_spans.push_back(sp);
        if (recent_spans.size() > iovart_pkg::TABLE_ENTRIES) begin
          void'(recent_spans.pop_front());
        end
        push_request(iovart_pkg::OP_ADD, a0, a1, b, o);
      end else if (pick < 95) begin
        case ($urandom_range(9))
          0: begin
            a0 = '0;
            a1 = ALL_ONES;
          end
          1: a1 = a0;
          2: ;
          3: begin
            a0 = 64'h4000_0000 + ($urandom_range(0, 63) << 8);
            a1 = a0 + $urandom_range(1, 20000);
          end
          4: begin
            a0 = lo;
            a1 = hi - 64'd1;
          end
          default: begin
            a0 = lo - $urandom_range(0, 2);
            a1 = hi + $urandom_range(0, 2);
          end
        endcase
        push_request(iovart_pkg::OP_REMOVE, a0, a1, b, o);
      end else begin
        push_request(OP_UNUSED, a0, a1, b, o);
      end
    end
    total_requests = request_fifo.size();

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    while (request_fifo.size() != 0 || start || outstanding_replies.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (iovart_pkg::TABLE_ENTRIES + 4) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS iova_region_translation_table_unit");
    end else begin
      $display("FAIL iova_region_translation_table_unit");
    end
    $finish;
  end

endmodule
